// File: hdl/sop_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segmented odd prime sieve package
// Shared types, codes, default sizes and the seed prime table.
// ----------------------------------------------------------------------------
package sop_pkg;

  localparam int TABLE_DEPTH_DEF = 4096;
  localparam int SEGMENT_LEN_DEF = 1024;
  localparam int VALUE_WIDTH_DEF = 32;

  localparam int SEED_COUNT = 99;
  localparam int SEED_LAST = 541;
  localparam int FIRST_START = 543;

  localparam logic REQ_SIEVE = 1'b0;
  localparam logic REQ_READ = 1'b1;

  localparam logic [1:0] STATUS_OK = 2'd0;
  localparam logic [1:0] STATUS_RANGE = 2'd1;
  localparam logic [1:0] STATUS_FULL = 2'd2;

  localparam logic OP_MUL = 1'b0;
  localparam logic OP_REM = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [11:0] prime_index;
  } req_t;

  typedef struct packed {
    logic [31:0] prime_value;
    logic [11:0] table_count;
    logic [1:0]  status;
  } rsp_t;

  typedef struct packed {
    logic go;
    logic op;
  } unit_cmd_t;

  localparam logic [9:0] SEED_PRIMES [0:SEED_COUNT-1] = '{
    10'd3, 10'd5, 10'd7, 10'd11, 10'd13, 10'd17, 10'd19, 10'd23, 10'd29, 10'd31,
    10'd37, 10'd41, 10'd43, 10'd47, 10'd53, 10'd59, 10'd61, 10'd67, 10'd71, 10'd73,
    10'd79, 10'd83, 10'd89, 10'd97, 10'd101, 10'd103, 10'd107, 10'd109, 10'd113,
    10'd127, 10'd131, 10'd137, 10'd139, 10'd149, 10'd151, 10'd157, 10'd163, 10'd167,
    10'd173, 10'd179, 10'd181, 10'd191, 10'd193, 10'd197, 10'd199, 10'd211, 10'd223,
    10'd227, 10'd229, 10'd233, 10'd239, 10'd241, 10'd251, 10'd257, 10'd263, 10'd269,
    10'd271, 10'd277, 10'd281, 10'd283, 10'd293, 10'd307, 10'd311, 10'd313, 10'd317,
    10'd331, 10'd337, 10'd347, 10'd349, 10'd353, 10'd359, 10'd367, 10'd373, 10'd379,
    10'd383, 10'd389, 10'd397, 10'd401, 10'd409, 10'd419, 10'd421, 10'd431, 10'd433,
    10'd439, 10'd443, 10'd449, 10'd457, 10'd461, 10'd463, 10'd467, 10'd479, 10'd487,
    10'd491, 10'd499, 10'd503, 10'd509, 10'd521, 10'd523, 10'(SEED_LAST)
  };

  function automatic logic [9:0] seed_prime(input logic [6:0] k);
    logic [9:0] v;
    v = 10'd0;
    if (k < 7'(SEED_COUNT)) begin
      v = SEED_PRIMES[k];
    end
    return v;
  endfunction

endpackage

// File: hdl/segmented_odd_prime_sieve.sv
`timescale 1ns / 1ps
// A read request passes through ST_RD to ST_DONE; out of range, straight to ST_DONE.
// So does a sieve request on a full table. Other sieve requests set the marks in
// ST_INIT, square and reduce each sieving prime in the shared unit, clear its marks
// in ST_MARK and collect candidates through ST_CREAD and ST_CCHK. One request at a
// time. After reset the table is seeded with the 99 seed primes.
// ----------------------------------------------------------------------------
// Segmented odd prime sieve
// Sequencer, prime table and mark memory around a shared arithmetic unit.
// ----------------------------------------------------------------------------
module segmented_odd_prime_sieve #(
  parameter int TABLE_DEPTH = sop_pkg::TABLE_DEPTH_DEF,
  parameter int SEGMENT_LEN = sop_pkg::SEGMENT_LEN_DEF,
  parameter int VALUE_WIDTH = sop_pkg::VALUE_WIDTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  sop_pkg::req_t req_data,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output sop_pkg::rsp_t rsp_data
);

  localparam int W = VALUE_WIDTH;
  localparam int PW = 2 * W;
  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int LW = $clog2(SEGMENT_LEN + 1);
  localparam int MAW = $clog2(SEGMENT_LEN);
  localparam int XW = ((AW > LW) ? AW : LW) + 2;
  localparam int MW = (AW > 12) ? AW : 12;
  localparam int SW = W + XW;

  localparam logic [3:0] ST_SEED = 4'd0;
  localparam logic [3:0] ST_IDLE = 4'd1;
  localparam logic [3:0] ST_RD = 4'd2;
  localparam logic [3:0] ST_SETUP = 4'd3;
  localparam logic [3:0] ST_INIT = 4'd4;
  localparam logic [3:0] ST_PFETCH = 4'd5;
  localparam logic [3:0] ST_PWAIT = 4'd6;
  localparam logic [3:0] ST_SQ = 4'd7;
  localparam logic [3:0] ST_REM = 4'd8;
  localparam logic [3:0] ST_OFS = 4'd9;
  localparam logic [3:0] ST_CLAMP = 4'd10;
  localparam logic [3:0] ST_JSET = 4'd11;
  localparam logic [3:0] ST_MARK = 4'd12;
  localparam logic [3:0] ST_CREAD = 4'd13;
  localparam logic [3:0] ST_CCHK = 4'd14;
  localparam logic [3:0] ST_DONE = 4'd15;

  logic [W-1:0] prime_table [0:TABLE_DEPTH-1];
  logic         marks [0:SEGMENT_LEN-1];

  logic [3:0]    state;
  logic [AW-1:0] pi;
  logic [AW-1:0] count;
  logic [W-1:0]  start;
  logic [W-1:0]  seg_end;
  logic [LW-1:0] seg_len;
  logic [LW-1:0] ci;
  logic [W-1:0]  p;
  logic [PW-1:0] pp;
  logic [W-1:0]  off;
  logic [W:0]    off2;
  logic [PW-1:0] d;
  logic          dpos;
  logic [PW-1:0] j;
  logic [W-1:0]  res_value;
  logic [1:0]    res_status;
  logic [W-1:0]  tbl_rd;
  logic          mark_rd;

  logic               accept;
  logic [MW-1:0]      idx_ext;
  logic [AW-1:0]      rd_addr;
  logic               tbl_we;
  logic [AW-1:0]      tbl_waddr;
  logic [W-1:0]       tbl_wdata;
  logic               mark_we;
  logic [MAW-1:0]     mark_waddr;
  logic               mark_wdata;
  logic [XW-1:0]      cnt_x;
  logic [XW-1:0]      len0;
  logic [XW-1:0]      free2;
  logic [XW-1:0]      len_c;
  logic [SW-1:0]      end_sum;
  logic [W-1:0]       cval;
  logic               pp_break;
  logic [W-1:0]       rem_r;
  logic [PW:0]        dsum;
  logic [PW-1:0]      jd;
  logic [W+31:0]      pv_ext;
  logic [AW+11:0]     tc_ext;
  sop_pkg::unit_cmd_t ucmd;
  logic [W-1:0]       ua;
  logic [W-1:0]       ub;
  logic               u_done;
  logic [PW-1:0]      u_result;

  assign req_stall = (state != ST_IDLE);
  assign accept = req_valid && !req_stall;
  assign idx_ext = MW'(req_data.prime_index);
  assign rd_addr = (state == ST_IDLE) ? idx_ext[AW-1:0] : pi;

  assign cnt_x = XW'(count);
  assign len0 = (cnt_x < XW'(SEGMENT_LEN)) ? cnt_x : XW'(SEGMENT_LEN);
  assign free2 = (XW'(TABLE_DEPTH) - cnt_x) << 1;
  assign len_c = (len0 + cnt_x > XW'(TABLE_DEPTH))
               ? ((free2 > XW'(SEGMENT_LEN)) ? XW'(SEGMENT_LEN) : free2) : len0;
  assign end_sum = SW'(start) + SW'(len_c << 1);

  assign cval = start + (W'(ci) << 1);
  assign pp_break = (seg_end == '0) || (u_result >= PW'(seg_end));
  assign rem_r = u_result[W-1:0];
  assign dsum = {1'b0, pp} - {1'b0, PW'(start)};
  assign jd = (dpos && (d > PW'(off2))) ? d : PW'(off2);

  assign pv_ext = (W + 32)'(res_value);
  assign tc_ext = (AW + 12)'(count);

  always_comb begin
    ucmd.go = 1'b0;
    ucmd.op = sop_pkg::OP_MUL;
    ua = start;
    ub = p;
    if (state == ST_PWAIT) begin
      ua = tbl_rd;
      ub = tbl_rd;
      ucmd.go = (tbl_rd >= W'(2));
    end else if (state == ST_SQ) begin
      ucmd.op = sop_pkg::OP_REM;
      ucmd.go = u_done && !pp_break;
    end
  end

  always_comb begin
    tbl_we = 1'b0;
    tbl_waddr = pi;
    tbl_wdata = W'(sop_pkg::seed_prime(pi[6:0]));
    mark_we = 1'b0;
    mark_waddr = ci[MAW-1:0];
    mark_wdata = 1'b1;
    case (state)
      ST_SEED: begin
        tbl_we = 1'b1;
      end
      ST_CCHK: begin
        tbl_we = mark_rd;
        tbl_waddr = count;
        tbl_wdata = cval;
      end
      ST_INIT: begin
        mark_we = (ci < seg_len);
      end
      ST_MARK: begin
        mark_we = (j < PW'(seg_len));
        mark_waddr = j[MAW-1:0];
        mark_wdata = 1'b0;
      end
      default: begin
        tbl_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      prime_table[tbl_waddr] <= tbl_wdata;
    end
    tbl_rd <= prime_table[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (mark_we) begin
      marks[mark_waddr] <= mark_wdata;
    end
    mark_rd <= marks[ci[MAW-1:0]];
  end

  sop_unit #(
    .W(W)
  ) u_unit (
    .clk(clk),
    .rst(rst),
    .cmd(ucmd),
    .a(ua),
    .b(ub),
    .done(u_done),
    .result(u_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_SEED;
      pi <= '0;
      count <= AW'(sop_pkg::SEED_COUNT);
      start <= W'(sop_pkg::FIRST_START);
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall && (state != ST_DONE)) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        ST_SEED: begin
          pi <= pi + 1'b1;
          if (pi == AW'(sop_pkg::SEED_COUNT - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            if (req_data.req_type == sop_pkg::REQ_READ) begin
              if (idx_ext < MW'(count)) begin
                state <= ST_RD;
              end else begin
                res_value <= W'(1);
                res_status <= sop_pkg::STATUS_RANGE;
                state <= ST_DONE;
              end
            end else if (count >= AW'(TABLE_DEPTH - 1)) begin
              res_value <= '0;
              res_status <= sop_pkg::STATUS_FULL;
              state <= ST_DONE;
            end else begin
              state <= ST_SETUP;
            end
          end
        end
        ST_RD: begin
          res_value <= tbl_rd;
          res_status <= sop_pkg::STATUS_OK;
          state <= ST_DONE;
        end
        ST_SETUP: begin
          seg_len <= LW'(len_c);
          seg_end <= end_sum[W-1:0];
          ci <= '0;
          state <= ST_INIT;
        end
        ST_INIT: begin
          if (ci < seg_len) begin
            ci <= ci + 1'b1;
          end else begin
            pi <= '0;
            state <= ST_PFETCH;
          end
        end
        ST_PFETCH: begin
          if (pi < count) begin
            state <= ST_PWAIT;
          end else begin
            ci <= '0;
            state <= ST_CREAD;
          end
        end
        ST_PWAIT: begin
          p <= tbl_rd;
          if (tbl_rd >= W'(2)) begin
            state <= ST_SQ;
          end else begin
            ci <= '0;
            state <= ST_CREAD;
          end
        end
        ST_SQ: begin
          if (u_done) begin
            pp <= u_result;
            if (pp_break) begin
              ci <= '0;
              state <= ST_CREAD;
            end else begin
              state <= ST_REM;
            end
          end
        end
        ST_REM: begin
          if (u_done) begin
            off <= (rem_r == '0) ? '0 : (p - rem_r);
            state <= ST_OFS;
          end
        end
        ST_OFS: begin
          off2 <= (W + 1)'(off) + ((start[0] ^ off[0]) ? '0 : (W + 1)'(p));
          state <= ST_CLAMP;
        end
        ST_CLAMP: begin
          d <= dsum[PW-1:0];
          dpos <= !dsum[PW];
          state <= ST_JSET;
        end
        ST_JSET: begin
          j <= jd >> 1;
          state <= ST_MARK;
        end
        ST_MARK: begin
          if (j < PW'(seg_len)) begin
            j <= j + PW'(p);
          end else begin
            pi <= pi + 1'b1;
            state <= ST_PFETCH;
          end
        end
        ST_CREAD: begin
          if (ci < seg_len) begin
            state <= ST_CCHK;
          end else begin
            start <= seg_end;
            res_value <= '0;
            res_status <= sop_pkg::STATUS_OK;
            state <= ST_DONE;
          end
        end
        ST_CCHK: begin
          ci <= ci + 1'b1;
          if (mark_rd) begin
            count <= count + 1'b1;
          end
          if (mark_rd && (count + 1'b1 == AW'(TABLE_DEPTH - 1))) begin
            start <= seg_end;
            res_value <= '0;
            res_status <= sop_pkg::STATUS_OK;
            state <= ST_DONE;
          end else begin
            state <= ST_CREAD;
          end
        end
        ST_DONE: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp_valid <= 1'b1;
            rsp_data.prime_value <= pv_ext[31:0];
            rsp_data.table_count <= tc_ext[11:0];
            rsp_data.status <= res_status;
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// File: hdl/sop_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shared multiply and remainder unit
// One adder serves a shift-add multiply and a restoring remainder, one bit
// per cycle.
// ----------------------------------------------------------------------------
module sop_unit #(
  parameter int W = sop_pkg::VALUE_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  sop_pkg::unit_cmd_t cmd,
  input  logic [W-1:0]       a,
  input  logic [W-1:0]       b,
  output logic               done,
  output logic [2*W-1:0]     result
);

  localparam int PW = 2 * W;
  localparam int CW = $clog2(W + 1);

  logic          busy;
  logic          op;
  logic [PW-1:0] acc;
  logic [PW-1:0] aux;
  logic [W-1:0]  bq;
  logic [CW-1:0] cnt;

  logic [PW-1:0] shifted;
  logic [PW-1:0] x;
  logic [PW-1:0] y;
  logic [PW:0]   sum;

  assign shifted = {acc[PW-2:0], aux[W-1]};
  assign x = (op == sop_pkg::OP_REM) ? shifted : acc;
  assign y = (op == sop_pkg::OP_REM) ? PW'(bq) : aux;
  assign sum = {1'b0, x} + {1'b0, ((op == sop_pkg::OP_REM) ? ~y : y)}
             + (PW + 1)'(op == sop_pkg::OP_REM);
  assign result = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      if (cmd.go) begin
        busy <= 1'b1;
        done <= 1'b0;
        op <= cmd.op;
        cnt <= '0;
        acc <= '0;
        aux <= PW'(a);
        bq <= b;
      end else if (busy) begin
        if (op == sop_pkg::OP_MUL) begin
          if (bq[0]) begin
            acc <= sum[PW-1:0];
          end
          bq <= bq >> 1;
        end else begin
          acc <= sum[PW] ? sum[PW-1:0] : shifted;
        end
        aux <= aux << 1;
        cnt <= cnt + 1'b1;
        if (cnt == CW'(W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          done <= 1'b0;
        end
      end else begin
        done <= 1'b0;
      end
    end
  end

endmodule
